/* sv/atfb_pkg.sv */
// Shared types and constants for the API transmit frame builder.
package atfb_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned AddrW = 64;
   localparam int unsigned StepW = 5;

   localparam logic [ByteW-1:0] SOF_BYTE      = 8'h7E;
   localparam logic [ByteW-1:0] LEN_HI_BYTE   = 8'h00;
   localparam logic [ByteW-1:0] LEN_BIAS      = 8'd14;
   localparam logic [ByteW-1:0] API_ID_TX_REQ = 8'h10;
   localparam logic [ByteW-1:0] FRAME_ID      = 8'h01;
   localparam logic [ByteW-1:0] NET16_HI      = 8'hFF;
   localparam logic [ByteW-1:0] NET16_LO      = 8'hFE;
   localparam logic [ByteW-1:0] RADIUS_BYTE   = 8'h00;
   localparam logic [ByteW-1:0] OPTIONS_BYTE  = 8'h00;
   localparam logic [ByteW-1:0] CKSUM_BASE    = 8'hFF;

   // Byte positions inside one frame
   localparam logic [StepW-1:0] STEP_SOF        = 5'd0;
   localparam logic [StepW-1:0] STEP_LEN_HI     = 5'd1;
   localparam logic [StepW-1:0] STEP_LEN_LO     = 5'd2;
   localparam logic [StepW-1:0] STEP_API_ID     = 5'd3;
   localparam logic [StepW-1:0] STEP_FRAME_ID   = 5'd4;
   localparam logic [StepW-1:0] STEP_ADDR_FIRST = 5'd5;
   localparam logic [StepW-1:0] STEP_ADDR_LAST  = 5'd12;
   localparam logic [StepW-1:0] STEP_NET_HI     = 5'd13;
   localparam logic [StepW-1:0] STEP_NET_LO     = 5'd14;
   localparam logic [StepW-1:0] STEP_RADIUS     = 5'd15;
   localparam logic [StepW-1:0] STEP_OPTIONS    = 5'd16;
   localparam logic [StepW-1:0] STEP_DATA       = 5'd17;
   localparam logic [StepW-1:0] STEP_CKSUM      = 5'd18;

   // CSR map
   localparam int unsigned CsrAddrW = 4;
   localparam logic [CsrAddrW-1:0] CSR_DEST_ADDRESS = 4'h0;

   // One classified payload word waiting for the serializer
   typedef struct packed {
      logic [ByteW-1:0] payload_byte;
      logic [ByteW-1:0] payload_length;
      logic             with_header;
      logic             frame_done;
      logic [AddrW-1:0] dest_address;
   } atfb_entry_type;

endpackage

/* sv/atfb_if.sv */
// Valid/ready channel interfaces for payload words and frame bytes.
interface atfb_req_if import atfb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] payload_byte;
   logic [ByteW-1:0] payload_length;

   modport source (output valid, output payload_byte, output payload_length, input ready);
   modport sink (input valid, input payload_byte, input payload_length, output ready);
endinterface

interface atfb_rsp_if import atfb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] frame_byte;
   logic             run_last;
   logic             frame_end;

   modport source (output valid, output frame_byte, output run_last, output frame_end,
                   input ready);
   modport sink (input valid, input frame_byte, input run_last, input frame_end,
                 output ready);
endinterface

/* sv/atfb_front.sv */
// Front end: CSR port, payload position tracking and word classification.
module atfb_front import atfb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [AddrW-1:0]    csr_pwdata,
   output logic [AddrW-1:0]    csr_prdata,
   output logic                csr_pready,
   input  logic                in_valid,
   input  logic [ByteW-1:0]    in_payload_byte,
   input  logic [ByteW-1:0]    in_payload_length,
   input  logic                queue_full,
   output logic                in_ready,
   output logic                push,
   output atfb_entry_type      push_entry
);

   logic [AddrW-1:0] dest_address_ff, dest_address_in;
   logic [ByteW-1:0] position_ff, position_in;
   logic             csr_write;
   logic             done;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_DEST_ADDRESS);
   assign csr_prdata = (csr_paddr == CSR_DEST_ADDRESS) ? dest_address_ff : '0;

   assign in_ready = !queue_full;
   assign push     = in_valid && in_ready;

   // Frame closes once the sent count reaches or passes this word's length
   assign done = ({1'b0, position_ff} + 9'd1) >= {1'b0, in_payload_length};

   always_comb begin
      dest_address_in = csr_write ? csr_pwdata : dest_address_ff;
      position_in     = position_ff;
      if (push) begin
         position_in = done ? '0 : position_ff + 8'd1;
      end
   end

   assign push_entry.payload_byte   = in_payload_byte;
   assign push_entry.payload_length = in_payload_length;
   assign push_entry.with_header    = (position_ff == '0);
   assign push_entry.frame_done     = done;
   assign push_entry.dest_address   = dest_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_address_ff <= '0;
         position_ff     <= '0;
      end else begin
         dest_address_ff <= dest_address_in;
         position_ff     <= position_in;
      end
   end

endmodule

/* sv/atfb_queue.sv */
// Short register queue between the classifier and the serializer.
module atfb_queue import atfb_pkg::*; #(
   parameter int unsigned Depth = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  atfb_entry_type push_entry,
   input  logic           pop,
   output logic           full,
   output logic           head_valid,
   output atfb_entry_type head_entry
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   atfb_entry_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/atfb_back.sv */
// Back end: serializes header, payload and checksum bytes into the output register.
module atfb_back import atfb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  atfb_entry_type head_entry,
   output logic           pop,
   input  logic           out_ready,
   output logic           out_valid,
   output logic [ByteW-1:0] out_frame_byte,
   output logic           out_run_last,
   output logic           out_frame_end
);

   logic [StepW-1:0] step_ff, step_in;
   logic [ByteW-1:0] sum_ff, sum_in;
   logic             valid_ff, valid_in;
   logic [ByteW-1:0] byte_ff, byte_in;
   logic             run_last_ff, run_last_in;
   logic             frame_end_ff, frame_end_in;

   logic [StepW-1:0] cur_step;
   logic [2:0]       addr_idx;
   logic [ByteW-1:0] cur_byte;
   logic             fire;
   logic             last;
   logic             summed;

   // A word without header starts right at its data byte
   assign cur_step = (step_ff == STEP_SOF && !head_entry.with_header) ? STEP_DATA : step_ff;
   assign addr_idx = 3'(STEP_ADDR_LAST - cur_step);
   assign fire     = head_valid && (!valid_ff || out_ready);
   assign last     = (cur_step == STEP_CKSUM)
                     || (cur_step == STEP_DATA && !head_entry.frame_done);
   assign pop      = fire && last;
   assign summed   = (cur_step >= STEP_API_ID) && (cur_step <= STEP_DATA);

   always_comb begin
      case (cur_step)
         STEP_SOF:      cur_byte = SOF_BYTE;
         STEP_LEN_HI:   cur_byte = LEN_HI_BYTE;
         STEP_LEN_LO:   cur_byte = head_entry.payload_length + LEN_BIAS;
         STEP_API_ID:   cur_byte = API_ID_TX_REQ;
         STEP_FRAME_ID: cur_byte = FRAME_ID;
         STEP_NET_HI:   cur_byte = NET16_HI;
         STEP_NET_LO:   cur_byte = NET16_LO;
         STEP_RADIUS:   cur_byte = RADIUS_BYTE;
         STEP_OPTIONS:  cur_byte = OPTIONS_BYTE;
         STEP_DATA:     cur_byte = head_entry.payload_byte;
         STEP_CKSUM:    cur_byte = CKSUM_BASE - sum_ff;
         default:       cur_byte = head_entry.dest_address[{addr_idx, 3'b000} +: ByteW];
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      sum_in       = sum_ff;
      valid_in     = valid_ff && !out_ready;
      byte_in      = byte_ff;
      run_last_in  = run_last_ff;
      frame_end_in = frame_end_ff;
      if (fire) begin
         step_in      = last ? STEP_SOF : cur_step + 1'b1;
         valid_in     = 1'b1;
         byte_in      = cur_byte;
         run_last_in  = last;
         frame_end_in = (cur_step == STEP_CKSUM);
         if (cur_step == STEP_SOF || cur_step == STEP_CKSUM) begin
            sum_in = '0;
         end else if (summed) begin
            sum_in = sum_ff + cur_byte;
         end
      end
   end

   assign out_valid      = valid_ff;
   assign out_frame_byte = byte_ff;
   assign out_run_last   = run_last_ff;
   assign out_frame_end  = frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_SOF;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      run_last_ff  <= run_last_in;
      frame_end_ff <= frame_end_in;
   end

endmodule

/* sv/api_transmit_frame_builder_unit.sv */
// Top level of the API transmit-request frame builder.
// Usage:
//   req_chan carries payload words (payload_byte, payload_length), one per frame
//   byte, each tagged with its frame's payload length. rsp_chan carries the
//   serialized frame one byte per word, with run_last on the final byte caused
//   by a payload word and frame_end on the checksum byte.
//   The first payload word of a frame yields 17 header bytes plus its data byte,
//   18 words, or 19 when it also closes the frame; later words yield one byte,
//   or two with the checksum. The serializer emits one byte per cycle while
//   the receiver keeps rsp_chan.ready high.
//   The first byte passes through a queue slot and then the output register
//   before it shows on rsp_chan.
//   A queue of QueueDepth classified words lets the input keep flowing while the
//   serializer works through a header or the receiver stalls; once it fills,
//   req_chan.ready drops until the serializer retires a word.
//   The destination address is written over csr_ at byte address 0 and is
//   sampled when the first word of a frame is accepted.
//   Reset clears the address, starts a new frame and empties the queue and
//   the output register.
module api_transmit_frame_builder_unit import atfb_pkg::*; #(
   parameter int unsigned QueueDepth = 4
) (
   input  logic                clock,
   input  logic                reset,
   atfb_req_if.sink            req_chan,
   atfb_rsp_if.source          rsp_chan,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [AddrW-1:0]    csr_pwdata,
   output logic [AddrW-1:0]    csr_prdata,
   output logic                csr_pready
);

   logic           queue_full;
   logic           push;
   logic           pop;
   logic           head_valid;
   atfb_entry_type push_entry;
   atfb_entry_type head_entry;

   atfb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .in_valid          (req_chan.valid),
      .in_payload_byte   (req_chan.payload_byte),
      .in_payload_length (req_chan.payload_length),
      .queue_full        (queue_full),
      .in_ready          (req_chan.ready),
      .push              (push),
      .push_entry        (push_entry)
   );

   atfb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   atfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .out_ready      (rsp_chan.ready),
      .out_valid      (rsp_chan.valid),
      .out_frame_byte (rsp_chan.frame_byte),
      .out_run_last   (rsp_chan.run_last),
      .out_frame_end  (rsp_chan.frame_end)
   );

endmodule

/* sv/atfb_checker.sv */
// Port-level checks for the frame builder, bound to the top level.
module atfb_checker import atfb_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [ByteW-1:0] rsp_frame_byte,
   input logic             rsp_run_last,
   input logic             rsp_frame_end,
   input logic             csr_pready
);

   // Output register empties on reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Checksum byte always closes the run of its payload word
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("frame_end without run_last");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte)
      && $stable(rsp_run_last) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // Nothing can come out before any word went in after reset
   a_no_early_rsp: assert property (@(posedge clock)
      $past(reset) && !reset |=> !rsp_valid)
      else $error("result before any accepted word");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("csr_pready low");

endmodule

bind api_transmit_frame_builder_unit atfb_checker u_atfb_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_frame_byte (rsp_chan.frame_byte),
   .rsp_run_last   (rsp_chan.run_last),
   .rsp_frame_end  (rsp_chan.frame_end),
   .csr_pready     (csr_pready)
);

/* test/testbench.sv */
// Testbench for the API transmit frame builder: framed payload words checked against a frame predictor.
`timescale 1ns / 1ps

module testbench;
   import atfb_pkg::*;

   localparam int IdleLimit = 5000;
   localparam int LongHold  = 400;
   localparam int EndDrain  = 12;
   localparam int PhaseSize = 25;

   typedef struct packed {
      logic [ByteW-1:0] frame_byte;
      logic             run_last;
      logic             frame_end;
   } frame_word_type;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_MOSTLY,
      RX_PERIODIC,
      RX_SPARSE
   } rx_mode_type;

   // Predicts the serialized frame bytes and compares them as they arrive.
   class frame_byte_tracker_type;
      logic [AddrW-1:0] dest_addr;
      logic [ByteW-1:0] payload_pos;
      logic [ByteW-1:0] byte_sum;
      frame_word_type   expected_bytes[$];
      int               errors;

      function new();
         dest_addr   = '0;
         payload_pos = '0;
         byte_sum    = '0;
         errors      = 0;
      endfunction

      function void write_dest(logic [AddrW-1:0] value);
         dest_addr = value;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void add_byte(logic [ByteW-1:0] b, bit summed, bit is_end);
         frame_word_type w;
         if (summed) byte_sum = byte_sum + b;
         w.frame_byte = b;
         w.run_last   = 1'b0;
         w.frame_end  = is_end;
         expected_bytes.push_back(w);
      endfunction

      function void note_payload(logic [ByteW-1:0] data, logic [ByteW-1:0] len);
         frame_word_type last_w;
         logic [ByteW-1:0] len_lo;
         len_lo = len + LEN_BIAS;
         if (payload_pos == '0) begin
            byte_sum = '0;
            add_byte(SOF_BYTE, 1'b0, 1'b0);
            add_byte(LEN_HI_BYTE, 1'b0, 1'b0);
            add_byte(len_lo, 1'b0, 1'b0);
            add_byte(API_ID_TX_REQ, 1'b1, 1'b0);
            add_byte(FRAME_ID, 1'b1, 1'b0);
            for (int k = 7; k >= 0; k--) add_byte(dest_addr[8*k +: 8], 1'b1, 1'b0);
            add_byte(NET16_HI, 1'b1, 1'b0);
            add_byte(NET16_LO, 1'b1, 1'b0);
            add_byte(RADIUS_BYTE, 1'b1, 1'b0);
            add_byte(OPTIONS_BYTE, 1'b1, 1'b0);
         end
         add_byte(data, 1'b1, 1'b0);
         // the length carried by each word decides where the frame closes
         if (int'(payload_pos) + 1 >= int'(len)) begin
            add_byte(CKSUM_BASE - byte_sum, 1'b0, 1'b1);
            payload_pos = '0;
            byte_sum    = '0;
         end else begin
            payload_pos = payload_pos + 8'd1;
         end
         last_w = expected_bytes.pop_back();
         last_w.run_last = 1'b1;
         expected_bytes.push_back(last_w);
      endfunction

      function void check_frame_byte(logic [ByteW-1:0] b, logic rl, logic fe);
         frame_word_type w;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected word, frame_byte %02h run_last %b frame_end %b",
                     $time, b, rl, fe);
            errors++;
            return;
         end
         w = expected_bytes.pop_front();
         if (b !== w.frame_byte) begin
            $display("%0t: frame_byte expected %02h actual %02h", $time, w.frame_byte, b);
            errors++;
         end
         if (rl !== w.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time, w.run_last, rl);
            errors++;
         end
         if (fe !== w.frame_end) begin
            $display("%0t: frame_end expected %b actual %b", $time, w.frame_end, fe);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   atfb_req_if req_if ();
   atfb_rsp_if rsp_if ();

   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [AddrW-1:0]    csr_pwdata;
   logic [AddrW-1:0]    csr_prdata;
   logic                csr_pready;

   frame_byte_tracker_type tracker;
   bit hold_results = 1'b0;
   int burst_left   = 0;
   int items_sent   = 0;
   int idle_cycles  = 0;

   api_transmit_frame_builder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   initial tracker = new();

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         tracker.note_payload(req_if.payload_byte, req_if.payload_length);
      if (!reset && rsp_if.valid && rsp_if.ready)
         tracker.check_frame_byte(rsp_if.frame_byte, rsp_if.run_last, rsp_if.frame_end);
   end

   initial begin : watchdog
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: ready follows a randomly chosen mode, redrawn when its run ends.
   initial begin : result_sink
      rx_mode_type mode;
      int mode_left;
      int period;
      int tick;
      mode      = RX_OPEN;
      mode_left = 0;
      period    = 2;
      tick      = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            // hold off long enough for the queue to fill and stall the input
            rsp_if.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            hold_results = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 4));
               mode_left = $urandom_range(20, 150);
               period    = $urandom_range(2, 5);
            end
            mode_left--;
            tick++;
            case (mode)
               RX_OPEN:     rsp_if.ready <= 1'b1;
               RX_COIN:     rsp_if.ready <= ($urandom_range(0, 1) == 1);
               RX_MOSTLY:   rsp_if.ready <= ($urandom_range(0, 9) < 8);
               RX_PERIODIC: rsp_if.ready <= ((tick % period) != 0);
               default:     rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic logic [ByteW-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [ByteW-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)  return 8'd0;
      if (r < 60) return 8'($urandom_range(1, 6));
      if (r < 85) return 8'($urandom_range(7, 24));
      if (r < 97) return 8'($urandom_range(25, 80));
      return 8'($urandom_range(128, 200));
   endfunction

   // Offer one payload word; return at the edge that accepts it.
   task automatic send_item(input logic [ByteW-1:0] b, input logic [ByteW-1:0] len);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(10, 20)) @(posedge clock);
         else
            repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      req_if.valid          <= 1'b1;
      req_if.payload_byte   <= b;
      req_if.payload_length <= len;
      @(posedge clock);
      while (!(req_if.valid && req_if.ready)) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_run(input logic [ByteW-1:0] len, input int count);
      for (int i = 0; i < count; i++) send_item(pick_byte(), len);
   endtask

   // Length changes word by word; close the frame where the block would.
   task automatic send_broken();
      int pos;
      bit done;
      logic [ByteW-1:0] len;
      pos  = 0;
      done = 1'b0;
      while (!done) begin
         len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 8));
         send_item(pick_byte(), len);
         if (pos + 1 >= int'(len)) done = 1'b1;
         else pos++;
      end
   endtask

   task automatic send_random_frame();
      logic [ByteW-1:0] len;
      if ($urandom_range(0, 9) < 8) begin
         len = pick_length();
         send_run(len, (len == 0) ? 1 : int'(len));
      end else begin
         send_broken();
      end
   endtask

   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Write the destination address, then read it back.
   task automatic write_dest(input logic [AddrW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_DEST_ADDRESS;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_dest(value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         $display("%0t: dest_address readback expected %016h actual %016h",
                  $time, value, csr_prdata);
         tracker.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : stimulus
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.payload_byte   <= '0;
      req_if.payload_length <= '0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-word and two-word frames at the byte extremes, zero length acts as one
      send_item(8'h00, 8'd1);
      send_item(8'hFF, 8'd1);
      send_item(8'hA5, 8'd0);
      send_item(8'hFF, 8'd2);
      send_item(8'h00, 8'd2);
      // oversize length wraps the length byte; a later word closes it early
      send_item(8'h5A, 8'd255);
      send_item(8'h81, 8'd1);
      send_item(8'h3C, 8'd241);
      send_item(8'hC3, 8'd2);
      // length changes inside the frame
      send_item(8'h11, 8'd3);
      send_item(8'h22, 8'd200);
      send_item(8'h33, 8'd3);

      wait_results_drained();
      write_dest({AddrW{1'b1}});
      send_item(8'h80, 8'd3);
      send_item(8'h7F, 8'd3);
      send_item(8'h01, 8'd3);
      // address write while a frame is open applies to the next frame
      send_item(8'h55, 8'd4);
      send_item(8'hAA, 8'd4);
      wait_results_drained();
      write_dest(64'h0123_4567_89AB_CDEF);
      send_item(8'hF0, 8'd4);
      send_item(8'h0F, 8'd4);
      send_item(8'h99, 8'd1);

      for (int ph = 0; ph < 4; ph++) begin
         wait_results_drained();
         case (ph)
            0:       write_dest({$urandom, $urandom});
            1:       write_dest('0);
            2:       write_dest({$urandom, $urandom});
            default: write_dest({AddrW{1'b1}});
         endcase
         if (ph == 1) hold_results = 1'b1;
         begin : phase_body
            int target;
            target = items_sent + PhaseSize;
            while (items_sent < target) send_random_frame();
         end
         if (ph == 2) begin
            send_run(8'd6, 3);
            wait_results_drained();
            write_dest({$urandom, $urandom});
            send_run(8'd6, 3);
         end
         if (ph == 3) send_run(8'd241, 241);
      end

      wait_results_drained();
      repeat (EndDrain) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
